// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file flm_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every enabled clock edge
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication, written by the caller with |-> or |=>
`define ASSERT_IMPLIES(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hw/rtl/flm_pkg.sv =====
// Package for the fixed latency line memory: widths, command codes,
// register indexes, reset values and control structs. No dependencies.
`timescale 1ns / 1ps

package flm_pkg;

  // default geometry
  localparam int SLOTS_DEF      = 4;
  localparam int LINE_WORDS_DEF = 8;
  localparam int MAIN_DEPTH_DEF = 1024;
  localparam int IMEM_DEPTH_DEF = 1024;

  // field widths
  localparam int CMD_W      = 3;
  localparam int ID_W       = 8;
  localparam int ADDR_W     = 32;
  localparam int WORD_W     = 32;
  localparam int IDX_W      = 10;
  localparam int LAT_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STAGE        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP          = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRELOAD_MAIN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PRELOAD_IMEM = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ_MAIN    = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMEM_PRESENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMEM_SIZE    = 2'd3;

  // register reset values
  localparam logic [LAT_W-1:0]  LATENCY_RST   = 8'd1;
  localparam logic [SIZE_W-1:0] MAIN_SIZE_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] IMEM_SIZE_RST = 11'd1024;

  // word returned for instruction reads past the bound
  localparam logic [WORD_W-1:0] IMEM_OOB_WORD = 32'hFFFF_FFFF;

  // sequencer to slot table
  typedef struct packed {
    logic              tick;
    logic              alloc;
    logic              free;
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   tag;
    logic [LAT_W-1:0]  lat;
  } flm_slot_ctrl_t;

  // slot table to sequencer
  typedef struct packed {
    logic              free_found;
    logic              done_found;
    logic              sel_commit;
    logic [ADDR_W-1:0] sel_addr;
    logic [ID_W-1:0]   sel_tag;
  } flm_slot_stat_t;

endpackage

// ===== hw/rtl/flm_req_if.sv =====
// Request channel interface: valid/ready plus the request fields.
// Depends on flm_pkg.
`timescale 1ns / 1ps

interface flm_req_if import flm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic              is_write;
  logic [ADDR_W-1:0] base_addr;
  logic [ID_W-1:0]   request_id;
  logic              imem_sel;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] word_value;

  modport source (output valid, cmd, is_write, base_addr, request_id, imem_sel,
                  word_index, word_value, input ready);
  modport sink (input valid, cmd, is_write, base_addr, request_id, imem_sel,
                word_index, word_value, output ready);
endinterface

// ===== hw/rtl/flm_rsp_if.sv =====
// Response channel interface: valid/ready plus the result fields.
// Depends on flm_pkg.
`timescale 1ns / 1ps

interface flm_rsp_if import flm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              resp_found;
  logic [ID_W-1:0]   resp_id;
  logic [WORD_W-1:0] resp_word;
  logic              last;

  modport source (output valid, accepted, resp_found, resp_id, resp_word, last,
                  input ready);
  modport sink (input valid, accepted, resp_found, resp_id, resp_word, last,
                output ready);
endinterface

// ===== hw/rtl/flm_slots.sv =====
// Outstanding request slot table: valid, countdown, address, tag per slot,
// first-free and first-complete search. Depends on flm_pkg.
`timescale 1ns / 1ps

module flm_slots import flm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int SW    = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  flm_slot_ctrl_t ctrl,
  input  logic [SW-1:0]  sel,
  output flm_slot_stat_t stat,
  output logic [SW-1:0]  free_idx,
  output logic [SW-1:0]  done_idx
);

  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  wr;
  logic [ADDR_W-1:0] addr [SLOTS];
  logic [ID_W-1:0]   tag  [SLOTS];
  logic [LAT_W-1:0]  cd   [SLOTS];
  logic              free_found;
  logic              done_found;

  // lowest free slot and lowest completed slot
  always_comb begin
    free_found = 1'b0;
    done_found = 1'b0;
    free_idx   = '0;
    done_idx   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
      if (valid[s] && cd[s] == '0) begin
        done_found = 1'b1;
        done_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    stat.free_found = free_found;
    stat.done_found = done_found;
    stat.sel_commit = valid[sel] && cd[sel] == '0 && wr[sel];
    stat.sel_addr   = addr[sel];
    stat.sel_tag    = tag[sel];
  end

  // countdown, allocation and release
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      wr    <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        cd[s] <= '0;
      end
    end else begin
      for (int s = 0; s < SLOTS; s++) begin
        if (ctrl.tick && valid[s] && cd[s] != '0) begin
          cd[s] <= cd[s] - LAT_W'(1);
        end
      end
      if (ctrl.alloc) begin
        valid[free_idx] <= 1'b1;
        wr[free_idx]    <= ctrl.is_write;
        addr[free_idx]  <= ctrl.addr;
        tag[free_idx]   <= ctrl.tag;
        cd[free_idx]    <= ctrl.lat;
      end
      if (ctrl.free) begin
        valid[sel] <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/fixed_latency_line_memory.sv =====
// Fixed latency line memory. One request at a time; ready only when idle.
// A tick runs a commit pass over every word of every slot, a line request
// fills a new slot word by word, and a pop of a completed slot gives one
// result per word; each line word takes a read state and then a write or
// output state. Results leave from one output register and wait on the
// response side. Reset (rst, synchronous) empties all slots and restores defaults.
`timescale 1ns / 1ps

module fixed_latency_line_memory import flm_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int LINE_WORDS = LINE_WORDS_DEF,
  parameter int MAIN_DEPTH = MAIN_DEPTH_DEF,
  parameter int IMEM_DEPTH = IMEM_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  flm_req_if.sink               req,
  flm_rsp_if.source             rsp
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int MAW = $clog2(MAIN_DEPTH);
  localparam int IAW = $clog2(IMEM_DEPTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [WW-1:0] WORD_LAST = WW'(LINE_WORDS - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DISP   = 11'b000_0000_0010,
    S_TK_RD  = 11'b000_0000_0100,
    S_TK_WR  = 11'b000_0000_1000,
    S_RQ_RD  = 11'b000_0001_0000,
    S_RQ_WR  = 11'b000_0010_0000,
    S_PP_RD  = 11'b000_0100_0000,
    S_PP_OUT = 11'b000_1000_0000,
    S_MRD    = 11'b001_0000_0000,
    S_MRD2   = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [LAT_W-1:0]  cfg_latency;
  logic              cfg_imem_present;
  logic [SIZE_W-1:0] cfg_main_size;
  logic [SIZE_W-1:0] cfg_imem_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_latency      <= LATENCY_RST;
      cfg_imem_present <= 1'b0;
      cfg_main_size    <= MAIN_SIZE_RST;
      cfg_imem_size    <= IMEM_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LATENCY:      cfg_latency      <= cfg_data[LAT_W-1:0];
        CFG_IMEM_PRESENT: cfg_imem_present <= cfg_data[0];
        CFG_MAIN_SIZE:    cfg_main_size    <= cfg_data[SIZE_W-1:0];
        CFG_IMEM_SIZE:    cfg_imem_size    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [CMD_W-1:0]  in_cmd;
  logic              in_wr;
  logic [ADDR_W-1:0] in_addr;
  logic [ID_W-1:0]   in_id;
  logic              in_imem;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] in_val;

  // sequencer registers
  logic [SW-1:0]     sc;
  logic [WW-1:0]     wc;
  logic              taken;
  logic              rq_mok;
  logic              rq_iok;
  logic              res_accepted;
  logic              res_found;
  logic [WORD_W-1:0] res_word;

  // output register
  logic              out_valid;
  logic              out_accepted;
  logic              out_found;
  logic [ID_W-1:0]   out_id;
  logic [WORD_W-1:0] out_word;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  // slot table
  flm_slot_ctrl_t ctrl;
  flm_slot_stat_t stat;
  logic [SW-1:0]  free_idx;
  logic [SW-1:0]  done_idx;

  flm_slots #(.SLOTS(SLOTS), .SW(SW)) u_slots (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sel      (sc),
    .stat     (stat),
    .free_idx (free_idx),
    .done_idx (done_idx)
  );

  // stores
  logic [WORD_W-1:0] main_store  [MAIN_DEPTH];
  logic [WORD_W-1:0] imem_store  [IMEM_DEPTH];
  logic [WORD_W-1:0] staged_line [LINE_WORDS];
  logic [WORD_W-1:0] slot_line   [SLOTS][LINE_WORDS];
  logic [WORD_W-1:0] main_rd;
  logic [WORD_W-1:0] imem_rd;
  logic [WORD_W-1:0] staged_rd;
  logic [WORD_W-1:0] line_rd;

  // word addresses and bound checks
  logic [31:0]       rq_wi;
  logic [31:0]       tk_wi;
  logic [31:0]       idx32;
  logic              rq_main_ok;
  logic              rq_imem_ok;
  logic              tk_ok;
  logic              idx_main_ok;
  logic              idx_imem_ok;
  logic              idx_stage_ok;
  logic [WORD_W-1:0] rq_word;
  logic [LAT_W-1:0]  lat_eff;

  assign rq_wi = {2'b00, in_addr[ADDR_W-1:2]} + 32'(wc);
  assign tk_wi = {2'b00, stat.sel_addr[ADDR_W-1:2]} + 32'(wc);
  assign idx32 = 32'(in_idx);
  assign rq_main_ok = rq_wi < 32'(cfg_main_size) && rq_wi < 32'(MAIN_DEPTH);
  assign rq_imem_ok = rq_wi < 32'(cfg_imem_size) && rq_wi < 32'(IMEM_DEPTH);
  assign tk_ok = tk_wi < 32'(cfg_main_size) && tk_wi < 32'(MAIN_DEPTH);
  assign idx_main_ok  = idx32 < 32'(MAIN_DEPTH);
  assign idx_imem_ok  = idx32 < 32'(IMEM_DEPTH);
  assign idx_stage_ok = idx32 < 32'(LINE_WORDS);
  assign lat_eff = (cfg_latency == '0) ? LAT_W'(1) : cfg_latency;

  // line word chosen for a request
  always_comb begin
    if (in_wr) begin
      rq_word = staged_rd;
    end else if (in_imem && cfg_imem_present) begin
      rq_word = rq_iok ? imem_rd : IMEM_OOB_WORD;
    end else begin
      rq_word = rq_mok ? main_rd : '0;
    end
  end

  // main store: one write, one registered read
  logic           main_we;
  logic [MAW-1:0] main_waddr;
  logic [MAW-1:0] main_raddr;
  logic [WORD_W-1:0] main_wdata;

  always_comb begin
    main_we    = (state == S_TK_WR && stat.sel_commit && tk_ok) ||
                 (state == S_DISP && in_cmd == CMD_PRELOAD_MAIN && idx_main_ok);
    main_waddr = (state == S_TK_WR) ? tk_wi[MAW-1:0] : idx32[MAW-1:0];
    main_wdata = (state == S_TK_WR) ? line_rd : in_val;
    main_raddr = (state == S_RQ_RD) ? rq_wi[MAW-1:0] : idx32[MAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_store[main_waddr] <= main_wdata;
    end
    main_rd <= main_store[main_raddr];
  end

  // instruction store
  always_ff @(posedge clk) begin
    if (state == S_DISP && in_cmd == CMD_PRELOAD_IMEM && idx_imem_ok) begin
      imem_store[idx32[IAW-1:0]] <= in_val;
    end
    imem_rd <= imem_store[rq_wi[IAW-1:0]];
  end

  // staging line
  always_ff @(posedge clk) begin
    if (state == S_DISP && in_cmd == CMD_STAGE && idx_stage_ok) begin
      staged_line[idx32[WW-1:0]] <= in_val;
    end
    staged_rd <= staged_line[wc];
  end

  // slot line data
  always_ff @(posedge clk) begin
    if (state == S_RQ_WR) begin
      slot_line[sc][wc] <= rq_word;
    end
    line_rd <= slot_line[sc][wc];
  end

  // slot table control
  always_comb begin
    ctrl.tick     = (state == S_DISP) && (in_cmd == CMD_TICK);
    ctrl.alloc    = (state == S_DISP) && (in_cmd == CMD_REQUEST) && !taken &&
                    stat.free_found;
    ctrl.free     = (state == S_PP_OUT) && out_free && (wc == WORD_LAST);
    ctrl.is_write = in_wr;
    ctrl.addr     = in_addr;
    ctrl.tag      = in_id;
    ctrl.lat      = lat_eff;
  end

  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = ((state == S_PP_OUT) || (state == S_RESULT)) && out_free;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid      = out_valid;
  assign rsp.accepted   = out_accepted;
  assign rsp.resp_found = out_found;
  assign rsp.resp_id    = out_id;
  assign rsp.resp_word  = out_word;
  assign rsp.last       = out_last;

  // capture of the accepted request
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      in_cmd  <= req.cmd;
      in_wr   <= req.is_write;
      in_addr <= req.base_addr;
      in_id   <= req.request_id;
      in_imem <= req.imem_sel;
      in_idx  <= req.word_index;
      in_val  <= req.word_value;
    end
    if (state == S_RQ_RD) begin
      rq_mok <= rq_main_ok;
      rq_iok <= rq_imem_ok;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sc           <= '0;
      wc           <= '0;
      taken        <= 1'b0;
      res_accepted <= 1'b0;
      res_found    <= 1'b0;
      res_word     <= '0;
      out_valid    <= 1'b0;
      out_accepted <= 1'b0;
      out_found    <= 1'b0;
      out_id       <= '0;
      out_word     <= '0;
      out_last     <= 1'b0;
    end else begin
      // output register valid: load wins over drain
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_accepted <= 1'b0;
          res_found    <= 1'b0;
          res_word     <= '0;
          sc           <= '0;
          wc           <= '0;
          case (in_cmd)
            CMD_TICK: begin
              taken <= 1'b0;
              state <= S_TK_RD;
            end
            CMD_REQUEST: begin
              if (!taken && stat.free_found) begin
                taken <= 1'b1;
                sc    <= free_idx;
                state <= S_RQ_RD;
              end else begin
                state <= S_RESULT;
              end
            end
            CMD_POP: begin
              if (stat.done_found) begin
                sc    <= done_idx;
                state <= S_PP_RD;
              end else begin
                state <= S_RESULT;
              end
            end
            CMD_READ_MAIN: state <= S_MRD;
            default:       state <= S_RESULT;
          endcase
        end
        // commit pass over every slot word
        S_TK_RD: state <= S_TK_WR;
        S_TK_WR: begin
          if (wc == WORD_LAST) begin
            wc <= '0;
            if (sc == SLOT_LAST) begin
              state <= S_RESULT;
            end else begin
              sc    <= sc + SW'(1);
              state <= S_TK_RD;
            end
          end else begin
            wc    <= wc + WW'(1);
            state <= S_TK_RD;
          end
        end
        // line capture for a new slot
        S_RQ_RD: state <= S_RQ_WR;
        S_RQ_WR: begin
          if (wc == WORD_LAST) begin
            res_accepted <= 1'b1;
            state        <= S_RESULT;
          end else begin
            wc    <= wc + WW'(1);
            state <= S_RQ_RD;
          end
        end
        // pop: one result per line word
        S_PP_RD: state <= S_PP_OUT;
        S_PP_OUT: begin
          if (out_free) begin
            out_accepted <= 1'b0;
            out_found    <= 1'b1;
            out_id       <= stat.sel_tag;
            out_word     <= line_rd;
            out_last     <= (wc == WORD_LAST);
            if (wc == WORD_LAST) begin
              state <= S_IDLE;
            end else begin
              wc    <= wc + WW'(1);
              state <= S_PP_RD;
            end
          end
        end
        S_MRD: state <= S_MRD2;
        S_MRD2: begin
          res_word <= idx_main_ok ? main_rd : '0;
          state    <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_accepted <= res_accepted;
            out_found    <= res_found;
            out_id       <= '0;
            out_word     <= res_word;
            out_last     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/flm_checker.sv =====
// Port-level checks for the fixed latency line memory, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flm_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_accepted,
  input logic rsp_found,
  input logic rsp_last
);

  // a stalled response stays offered
  `ASSERT_IMPLIES(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready |=> rsp_valid), "rsp dropped")

  // a request that took a slot never also reports a found line
  `ASSERT_ALWAYS(a_acc_found, clk, rst, (!(rsp_valid && rsp_accepted && rsp_found)), "acc+found")

  // everything but a found pop is a single result
  `ASSERT_IMPLIES(a_single, clk, rst, (rsp_valid && !rsp_found |-> rsp_last), "not last")

  // the block is busy in the cycle after taking a request
  `ASSERT_IMPLIES(a_busy, clk, rst, (req_valid && req_ready |=> !req_ready), "ready while busy")

endmodule

bind fixed_latency_line_memory flm_checker u_flm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_accepted (rsp.accepted),
  .rsp_found    (rsp.resp_found),
  .rsp_last     (rsp.last)
);
